// ----- hw/rtl/adam_parameter_update_macros.svh -----
// Assertion macros shared by the Adam parameter update RTL.
// Depends on nothing; included by the top level.
`ifndef ADAM_PARAMETER_UPDATE_MACROS_SVH
`define ADAM_PARAMETER_UPDATE_MACROS_SVH

// Same-cycle implication under the block's clock and reset.
`define ADU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adu assertion failed");

// Next-cycle implication under the block's clock and reset.
`define ADU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adu assertion failed");

`endif

// ----- hw/rtl/adu_pkg.sv -----
// Package for the Adam parameter update block: register indexes, reset values,
// queue item and status types. Depends on nothing.
package adu_pkg;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_ONE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_TWO       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STABILITY_TERM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT     = 3'd4;

    localparam logic [23:0] RST_BETA_ONE       = 24'd15099494;
    localparam logic [23:0] RST_BETA_TWO       = 24'd16760438;
    localparam logic [31:0] RST_LEARNING_RATE  = 32'd4294967;
    localparam logic [31:0] RST_STABILITY_TERM = 32'd43;
    localparam logic [15:0] RST_STEP_COUNT     = 16'd1;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Updated moments and the weight, handed from the front to the back.
    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] mn;
        logic [30:0]        sn;
    } adu_item_t;

    typedef struct packed {
        logic valid;
        logic full;
    } adu_qstat_t;

    // Bias correction terms 1 - beta^t in Q0.32, 33 bits wide.
    typedef struct packed {
        logic        busy;
        logic [32:0] c1;
        logic [32:0] c2;
    } adu_coef_t;

endpackage

// ----- hw/rtl/adam_parameter_update.sv -----
// Adam parameter update, top level: one element per cycle while busy is low, fixed latency.
// done rises after the front, the queue and the back pipelines; the receiver cannot stall.
// Throughput is one element per cycle while busy is low; the long divider and root
// chains are fully pipelined. busy is high after reset and after every register
// write while the shared multiplier forms 1 - beta^t.
// Depends on adu_pkg, adu_coef, adu_front, adu_queue, adu_back and the macros.
module adam_parameter_update #(
    parameter int QUEUE_DEPTH = adu_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [31:0]             weight_in,
    input  logic signed [31:0]             gradient,
    input  logic signed [31:0]             first_moment_in,
    input  logic [30:0]                    second_moment_in,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [adu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data,
    output logic                           done,
    output logic signed [31:0]             weight_out,
    output logic signed [31:0]             first_moment_out,
    output logic [30:0]                    second_moment_out
);
    import adu_pkg::*;

    `include "adam_parameter_update_macros.svh"

    // Configuration registers; writes are taken every cycle.
    logic [23:0] beta_one_reg, beta_two_reg;
    logic [31:0] lr_reg, eps_reg;
    logic [15:0] step_reg;
    logic        cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_one_reg <= RST_BETA_ONE;
            beta_two_reg <= RST_BETA_TWO;
            lr_reg       <= RST_LEARNING_RATE;
            eps_reg      <= RST_STABILITY_TERM;
            step_reg     <= RST_STEP_COUNT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_BETA_ONE:       beta_one_reg <= cfg_data[23:0];
                CFG_BETA_TWO:       beta_two_reg <= cfg_data[23:0];
                CFG_LEARNING_RATE:  lr_reg       <= cfg_data;
                CFG_STABILITY_TERM: eps_reg      <= cfg_data;
                CFG_STEP_COUNT:     step_reg     <= cfg_data[15:0];
                default:            ;
            endcase
        end
    end

    // Recompute the bias correction terms on every configuration write.
    adu_coef_t coef;

    adu_coef u_coef (
        .clk(clk), .rst_n(rst_n), .recalc(cfg_write), .beta_one(beta_one_reg),
        .beta_two(beta_two_reg), .step_count(step_reg), .coef(coef)
    );

    assign busy = coef.busy;

    // Front: accept a transfer and form the updated moments.
    logic      accept;
    logic      front_valid;
    adu_item_t front_item;

    assign accept = start & ~busy;

    adu_front u_front (
        .clk(clk), .rst_n(rst_n), .accept(accept), .weight_in(weight_in),
        .gradient(gradient), .first_moment_in(first_moment_in),
        .second_moment_in(second_moment_in), .beta_one(beta_one_reg),
        .beta_two(beta_two_reg), .item_valid(front_valid), .item(front_item)
    );

    // Queue between front and back; the back drains it every cycle.
    adu_qstat_t qstat;
    adu_item_t  q_head;

    adu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(front_valid), .push_item(front_item),
        .pop(qstat.valid), .stat(qstat), .head(q_head)
    );

    // Back: corrected moments, root, step and weight.
    adu_back u_back (
        .clk(clk), .rst_n(rst_n), .item_valid(qstat.valid), .item(q_head),
        .learning_rate(lr_reg), .stability_term(eps_reg), .c1(coef.c1), .c2(coef.c2),
        .done(done), .weight_out(weight_out), .first_moment_out(first_moment_out),
        .second_moment_out(second_moment_out)
    );

    // A register write must hold off new elements until the terms are fresh.
    `ADU_ASSERT_NEXT(a_cfg_busy, clk, rst_n, cfg_write, busy)
    // The back never stalls, so the queue must never overflow.
    `ADU_ASSERT_NOW(a_queue_no_overflow, clk, rst_n, front_valid, !qstat.full)
    // No element may enter while the terms are being formed.
    `ADU_ASSERT_NOW(a_no_accept_busy, clk, rst_n, coef.busy, !accept)

endmodule

// ----- hw/rtl/adu_coef.sv -----
// Bias correction sequencer: computes 1 - beta^t for both betas by
// square-and-multiply on one shared multiplier. Depends on adu_pkg.
module adu_coef (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               recalc,
    input  logic [23:0]        beta_one,
    input  logic [23:0]        beta_two,
    input  logic [15:0]        step_count,
    output adu_pkg::adu_coef_t coef
);
    import adu_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_SQR   = 5'b00100,
        ST_MUL   = 5'b01000,
        ST_STORE = 5'b10000
    } coef_state_t;

    coef_state_t state_reg, state_next;
    logic        pending_reg, pending_next;
    logic        sel_reg, sel_next;
    logic [3:0]  k_reg, k_next;
    logic [31:0] acc_reg, acc_next;
    logic [32:0] c1_reg, c1_next;
    logic [32:0] c2_reg, c2_next;

    logic [15:0] t_eff;
    logic [3:0]  top_bit;
    logic [31:0] base;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [31:0] mul_res;

    assign t_eff = (step_count == 16'd0) ? 16'd1 : step_count;
    assign base  = sel_reg ? {beta_two, 8'b0} : {beta_one, 8'b0};

    always_comb
    begin
        top_bit = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (t_eff[i])
            begin
                top_bit = 4'(i);
            end
        end
    end

    // Round-to-nearest Q0.32 product.
    assign mul_b   = (state_reg == ST_MUL) ? base : acc_reg;
    assign prod    = 64'(acc_reg) * 64'(mul_b) + 64'h8000_0000;
    assign mul_res = prod[63:32];

    always_comb
    begin
        state_next   = state_reg;
        pending_next = pending_reg | recalc;
        sel_next     = sel_reg;
        k_next       = k_reg;
        acc_next     = acc_reg;
        c1_next      = c1_reg;
        c2_next      = c2_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pending_reg)
                begin
                    pending_next = recalc;
                    sel_next     = 1'b0;
                    state_next   = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                acc_next = base;
                if (top_bit == 4'd0)
                begin
                    state_next = ST_STORE;
                end
                else
                begin
                    k_next     = top_bit - 4'd1;
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                acc_next = mul_res;
                if (t_eff[k_reg])
                begin
                    state_next = ST_MUL;
                end
                else if (k_reg == 4'd0)
                begin
                    state_next = ST_STORE;
                end
                else
                begin
                    k_next = k_reg - 4'd1;
                end
            end
            ST_MUL:
            begin
                acc_next = mul_res;
                if (k_reg == 4'd0)
                begin
                    state_next = ST_STORE;
                end
                else
                begin
                    k_next     = k_reg - 4'd1;
                    state_next = ST_SQR;
                end
            end
            ST_STORE:
            begin
                if (sel_reg)
                begin
                    c2_next    = {1'b1, 32'b0} - {1'b0, acc_reg};
                    state_next = ST_IDLE;
                end
                else
                begin
                    c1_next    = {1'b1, 32'b0} - {1'b0, acc_reg};
                    sel_next   = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pending_reg <= 1'b1;
            sel_reg     <= 1'b0;
            k_reg       <= 4'd0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            sel_reg     <= sel_next;
            k_reg       <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        c1_reg  <= c1_next;
        c2_reg  <= c2_next;
    end

    assign coef.busy = (state_reg != ST_IDLE) | pending_reg;
    assign coef.c1   = c1_reg;
    assign coef.c2   = c2_reg;

endmodule

// ----- hw/rtl/adu_front.sv -----
// Front part: takes an input element and computes both updated moments in a
// three-stage pipeline. Depends on adu_pkg.
module adu_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic signed [31:0] weight_in,
    input  logic signed [31:0] gradient,
    input  logic signed [31:0] first_moment_in,
    input  logic [30:0]        second_moment_in,
    input  logic [23:0]        beta_one,
    input  logic [23:0]        beta_two,
    output logic               item_valid,
    output adu_pkg::adu_item_t item
);
    import adu_pkg::*;

    logic               v1_reg, v2_reg, v3_reg;
    logic signed [31:0] w1_reg, w2_reg;
    logic signed [56:0] p1_reg, p1_next;
    logic signed [57:0] p2_reg, p2_next;
    logic signed [63:0] gg_reg, gg_next;
    logic [54:0]        bs1_reg, bs2_reg, bs_next;
    logic [24:0]        om1, om2;

    logic signed [58:0] msum;
    logic signed [34:0] msh;
    logic signed [31:0] mn2_reg, mn2_next;
    logic [63:0]        gsum;
    logic [38:0]        g2;
    logic [44:0]        sph_reg, sph_next;
    logic [43:0]        spl_reg, spl_next;

    logic [63:0]        ssum;
    logic [39:0]        sh;
    adu_item_t          item_reg, item_next;

    // Stage 1: products of the raw fields.
    assign om1     = 25'h100_0000 - {1'b0, beta_one};
    assign p1_next = $signed({1'b0, beta_one}) * first_moment_in;
    assign p2_next = $signed({1'b0, om1}) * gradient;
    assign gg_next = gradient * gradient;
    assign bs_next = 55'(beta_two) * 55'(second_moment_in);

    // Stage 2: first moment, squared gradient scaled and weighted.
    assign msum = 59'(p1_reg) + 59'(p2_reg) + 59'sd8388608;
    assign msh  = msum[58:24];
    always_comb
    begin
        if (msh > 35'sd2147483647)
        begin
            mn2_next = 32'sh7FFF_FFFF;
        end
        else if (msh < -35'sd2147483648)
        begin
            mn2_next = 32'sh8000_0000;
        end
        else
        begin
            mn2_next = msh[31:0];
        end
    end
    assign gsum     = $unsigned(gg_reg) + 64'd8388608;
    assign g2       = gsum[62:24];
    assign om2      = 25'h100_0000 - {1'b0, beta_two};
    assign sph_next = 45'(om2) * 45'(g2[38:19]);
    assign spl_next = 44'(om2) * 44'(g2[18:0]);

    // Stage 3: second moment, saturated to 31 bits.
    assign ssum = 64'(bs2_reg) + {sph_reg, 19'b0} + 64'(spl_reg) + 64'd8388608;
    assign sh   = ssum[63:24];
    always_comb
    begin
        item_next.w  = w2_reg;
        item_next.mn = mn2_reg;
        item_next.sn = (|sh[39:31]) ? 31'h7FFF_FFFF : sh[30:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        w1_reg   <= weight_in;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        gg_reg   <= gg_next;
        bs1_reg  <= bs_next;
        w2_reg   <= w1_reg;
        mn2_reg  <= mn2_next;
        bs2_reg  <= bs1_reg;
        sph_reg  <= sph_next;
        spl_reg  <= spl_next;
        item_reg <= item_next;
    end

    assign item_valid = v3_reg;
    assign item       = item_reg;

endmodule

// ----- hw/rtl/adu_queue.sv -----
// Short queue that decouples the front from the back.
// Depends on adu_pkg.
module adu_queue #(
    parameter int DEPTH = adu_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  adu_pkg::adu_item_t  push_item,
    input  logic                pop,
    output adu_pkg::adu_qstat_t stat,
    output adu_pkg::adu_item_t  head
);
    import adu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    adu_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign do_pop  = pop && (cnt_reg != '0);
    assign do_push = push && (cnt_reg != CNT_W'(DEPTH));

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_item;
        end
    end

    assign stat.valid = (cnt_reg != '0);
    assign stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign head       = mem_reg[rd_reg];

endmodule

// ----- hw/rtl/adu_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// The starting remainder must be below the divisor. Depends on nothing.
module adu_div_pipe #(
    parameter int DW = 33,
    parameter int QW = 40,
    parameter int PW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [QW-1:0] in_low,
    input  logic [DW-1:0] in_div,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [QW-1:0] out_quo,
    output logic [PW-1:0] out_pay
);

    logic          st_vld [QW+1];
    logic [DW-1:0] st_rem [QW+1];
    logic [QW-1:0] st_low [QW+1];
    logic [QW-1:0] st_quo [QW+1];
    logic [DW-1:0] st_div [QW+1];
    logic [PW-1:0] st_pay [QW+1];

    logic          vld_reg [QW];
    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [DW-1:0] div_reg [QW];
    logic [PW-1:0] pay_reg [QW];

    assign st_vld[0] = in_valid;
    assign st_rem[0] = in_rem;
    assign st_low[0] = in_low;
    assign st_quo[0] = '0;
    assign st_div[0] = in_div;
    assign st_pay[0] = in_pay;

    genvar i;
    for (i = 0; i < QW; i++)
    begin : g_stage
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;

        assign trial = {st_rem[i], st_low[i][QW-1]};
        assign diff  = trial - {1'b0, st_div[i]};
        assign ge    = (trial >= {1'b0, st_div[i]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else
            begin
                vld_reg[i] <= st_vld[i];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
            low_reg[i] <= {st_low[i][QW-2:0], 1'b0};
            quo_reg[i] <= {st_quo[i][QW-2:0], ge};
            div_reg[i] <= st_div[i];
            pay_reg[i] <= st_pay[i];
        end

        assign st_vld[i+1] = vld_reg[i];
        assign st_rem[i+1] = rem_reg[i];
        assign st_low[i+1] = low_reg[i];
        assign st_quo[i+1] = quo_reg[i];
        assign st_div[i+1] = div_reg[i];
        assign st_pay[i+1] = pay_reg[i];
    end

    assign out_valid = st_vld[QW];
    assign out_quo   = st_quo[QW];
    assign out_pay   = st_pay[QW];

endmodule

// ----- hw/rtl/adu_back.sv -----
// Back part: bias correction divides, square root, step divide and weight
// update, all fully pipelined. Depends on adu_pkg and adu_div_pipe.
module adu_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  adu_pkg::adu_item_t item,
    input  logic [31:0]        learning_rate,
    input  logic [31:0]        stability_term,
    input  logic [32:0]        c1,
    input  logic [32:0]        c2,
    output logic               done,
    output logic signed [31:0] weight_out,
    output logic signed [31:0] first_moment_out,
    output logic [30:0]        second_moment_out
);
    import adu_pkg::*;

    localparam int SQ_STEPS = 32;

    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] mn;
        logic [30:0]        sn;
        logic               sat;
    } mpay_t;

    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] mn;
        logic [30:0]        sn;
        logic [39:0]        mhat;
    } sq_pay_t;

    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] mn;
        logic [30:0]        sn;
        logic               cap;
        logic               zq;
    } fpay_t;

    // Stage 0: magnitude and saturation checks for the moment divides.
    logic        b0v_reg;
    logic [31:0] mag;
    logic [32:0] r1_reg, r2_reg;
    logic [39:0] l1_reg, l2_reg;
    mpay_t       mp_reg, mp_next;
    logic        sat2_reg;

    assign mag = item.mn[31] ? (~item.mn + 32'd1) : item.mn;
    always_comb
    begin
        mp_next.w   = item.w;
        mp_next.mn  = item.mn;
        mp_next.sn  = item.sn;
        mp_next.sat = ({9'b0, mag[31:8]} >= c1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0v_reg <= 1'b0;
        end
        else
        begin
            b0v_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        r1_reg   <= {9'b0, mag[31:8]};
        l1_reg   <= {mag[7:0], 32'b0};
        r2_reg   <= {10'b0, item.sn[30:8]};
        l2_reg   <= {item.sn[7:0], 32'b0};
        sat2_reg <= ({10'b0, item.sn[30:8]} >= c2);
        mp_reg   <= mp_next;
    end

    // Moment divides by the bias correction terms.
    logic        d1v, d2v;
    logic [39:0] q1, q2;
    mpay_t       mp_out;
    logic        sat2_out;

    adu_div_pipe #(.DW(33), .QW(40), .PW($bits(mpay_t))) u_div_m (
        .clk(clk), .rst_n(rst_n), .in_valid(b0v_reg), .in_rem(r1_reg), .in_low(l1_reg),
        .in_div(c1), .in_pay(mp_reg), .out_valid(d1v), .out_quo(q1), .out_pay(mp_out)
    );

    adu_div_pipe #(.DW(33), .QW(40), .PW(1)) u_div_s (
        .clk(clk), .rst_n(rst_n), .in_valid(b0v_reg), .in_rem(r2_reg), .in_low(l2_reg),
        .in_div(c2), .in_pay(sat2_reg), .out_valid(d2v), .out_quo(q2), .out_pay(sat2_out)
    );

    // Saturate the corrected moments.
    logic        hv_reg;
    sq_pay_t     hp_reg;
    logic [39:0] shat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg <= 1'b0;
        end
        else
        begin
            hv_reg <= d1v & d2v;
        end
    end

    always_ff @(posedge clk)
    begin
        hp_reg.w    <= mp_out.w;
        hp_reg.mn   <= mp_out.mn;
        hp_reg.sn   <= mp_out.sn;
        hp_reg.mhat <= mp_out.sat ? 40'hFF_FFFF_FFFF : q1;
        shat_reg    <= sat2_out ? 40'hFF_FFFF_FFFF : q2;
    end

    // Square root of shat * 2^24, two radicand bits per stage.
    logic        sq_vld [SQ_STEPS+1];
    logic [33:0] sq_rem [SQ_STEPS+1];
    logic [31:0] sq_root [SQ_STEPS+1];
    logic [63:0] sq_x [SQ_STEPS+1];
    sq_pay_t     sq_pay [SQ_STEPS+1];

    logic        sqv_reg [SQ_STEPS];
    logic [33:0] sqr_reg [SQ_STEPS];
    logic [31:0] sqt_reg [SQ_STEPS];
    logic [63:0] sqx_reg [SQ_STEPS];
    sq_pay_t     sqp_reg [SQ_STEPS];

    assign sq_vld[0]  = hv_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_x[0]    = {shat_reg, 24'b0};
    assign sq_pay[0]  = hp_reg;

    genvar j;
    for (j = 0; j < SQ_STEPS; j++)
    begin : g_sqrt
        logic [35:0] cur;
        logic [35:0] trial;
        logic [35:0] diff;
        logic        ge;

        assign cur   = {sq_rem[j], sq_x[j][63:62]};
        assign trial = {2'b0, sq_root[j], 2'b01};
        assign diff  = cur - trial;
        assign ge    = (cur >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sqv_reg[j] <= 1'b0;
            end
            else
            begin
                sqv_reg[j] <= sq_vld[j];
            end
        end

        always_ff @(posedge clk)
        begin
            sqr_reg[j] <= ge ? diff[33:0] : cur[33:0];
            sqt_reg[j] <= {sq_root[j][30:0], ge};
            sqx_reg[j] <= {sq_x[j][61:0], 2'b00};
            sqp_reg[j] <= sq_pay[j];
        end

        assign sq_vld[j+1]  = sqv_reg[j];
        assign sq_rem[j+1]  = sqr_reg[j];
        assign sq_root[j+1] = sqt_reg[j];
        assign sq_x[j+1]    = sqx_reg[j];
        assign sq_pay[j+1]  = sqp_reg[j];
    end

    // Denominator and split learning rate product.
    logic        mv_reg;
    logic [40:0] denom_reg;
    logic [51:0] ph_reg, pl_reg;
    sq_pay_t     mpy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= 1'b0;
        end
        else
        begin
            mv_reg <= sq_vld[SQ_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        denom_reg <= {1'b0, sq_root[SQ_STEPS], 8'b0} + {9'b0, stability_term};
        ph_reg    <= 52'(learning_rate) * 52'(sq_pay[SQ_STEPS].mhat[39:20]);
        pl_reg    <= 52'(learning_rate) * 52'(sq_pay[SQ_STEPS].mhat[19:0]);
        mpy_reg   <= sq_pay[SQ_STEPS];
    end

    // Full product, step cap and zero-denominator handling.
    logic        pv_reg;
    logic [71:0] prod;
    logic        dzero, mnz, cap;
    logic [40:0] pr_reg, pd_reg;
    logic [31:0] plo_reg;
    fpay_t       fp_reg;

    assign prod  = {ph_reg, 20'b0} + {20'b0, pl_reg};
    assign dzero = (denom_reg == '0);
    assign mnz   = (mpy_reg.mhat != '0);
    assign cap   = dzero ? mnz : ({1'b0, prod[71:32]} >= denom_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= mv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pr_reg    <= cap ? 41'd0 : {1'b0, prod[71:32]};
        plo_reg   <= prod[31:0];
        pd_reg    <= denom_reg;
        fp_reg.w  <= mpy_reg.w;
        fp_reg.mn <= mpy_reg.mn;
        fp_reg.sn <= mpy_reg.sn;
        fp_reg.cap <= cap;
        fp_reg.zq  <= dzero & ~mnz;
    end

    logic        fv;
    logic [31:0] qd;
    fpay_t       fp_out;

    adu_div_pipe #(.DW(41), .QW(32), .PW($bits(fpay_t))) u_div_step (
        .clk(clk), .rst_n(rst_n), .in_valid(pv_reg), .in_rem(pr_reg), .in_low(plo_reg),
        .in_div(pd_reg), .in_pay(fp_reg), .out_valid(fv), .out_quo(qd), .out_pay(fp_out)
    );

    // Apply the step with the sign of the first moment and saturate.
    logic [32:0]        q33;
    logic signed [34:0] w35, q35, wn;
    logic signed [31:0] wsat;
    logic               done_reg;
    logic signed [31:0] wo_reg, mo_reg;
    logic [30:0]        so_reg;

    always_comb
    begin
        if (fp_out.cap)
        begin
            q33 = {1'b1, 32'b0};
        end
        else if (fp_out.zq)
        begin
            q33 = '0;
        end
        else
        begin
            q33 = {1'b0, qd};
        end
        w35 = 35'(fp_out.w);
        q35 = $signed({2'b0, q33});
        wn  = fp_out.mn[31] ? (w35 + q35) : (w35 - q35);
        if (wn > 35'sd2147483647)
        begin
            wsat = 32'sh7FFF_FFFF;
        end
        else if (wn < -35'sd2147483648)
        begin
            wsat = 32'sh8000_0000;
        end
        else
        begin
            wsat = wn[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fv;
        end
    end

    always_ff @(posedge clk)
    begin
        wo_reg <= wsat;
        mo_reg <= fp_out.mn;
        so_reg <= fp_out.sn;
    end

    assign done              = done_reg;
    assign weight_out        = wo_reg;
    assign first_moment_out  = mo_reg;
    assign second_moment_out = so_reg;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for adam_parameter_update: drives directed and random
// elements under several register settings and checks every result against a
// predictor or a hand-typed result. Depends on adu_pkg and the adam_parameter_update RTL.
module tb_top;
    import adu_pkg::*;

    localparam int LATENCY_WAIT = 160;   // wait past the block latency, with margin
    localparam int ITEMS_PER_SETTING = 440;

    typedef struct {
        logic signed [31:0] w;
        logic signed [31:0] m;
        logic [30:0]        s;
    } adam_result_t;

    // One row of the directed table; has_typed marks a hand-typed expectation.
    typedef struct {
        logic signed [31:0] w;
        logic signed [31:0] g;
        logic signed [31:0] m;
        logic [30:0]        s;
        bit                 has_typed;
        adam_result_t       typed;
    } directed_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] weight_in;
    logic signed [31:0] gradient;
    logic signed [31:0] first_moment_in;
    logic [30:0]        second_moment_in;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]        cfg_data;
    logic               done;
    logic signed [31:0] weight_out;
    logic signed [31:0] first_moment_out;
    logic [30:0]        second_moment_out;

    // Predictor copy of the registers.
    logic [23:0] decay_one;
    logic [23:0] decay_two;
    logic [31:0] step_size;
    logic [31:0] epsilon_q32;
    logic [15:0] iteration;

    adam_result_t pending_updates[$];
    int           mismatches;
    int           updates_checked;
    int           elements_sent;

    adam_parameter_update dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .weight_in         (weight_in),
        .gradient          (gradient),
        .first_moment_in   (first_moment_in),
        .second_moment_in  (second_moment_in),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .done              (done),
        .weight_out        (weight_out),
        .first_moment_out  (first_moment_out),
        .second_moment_out (second_moment_out)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic longint clamp_s32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned round_mul_q32(longint unsigned a, longint unsigned b);
        return (a * b + 64'h8000_0000) >> 32;
    endfunction

    // 1 - beta^t in Q0.32; square-and-multiply from the top set bit of t.
    function automatic longint unsigned decay_complement(logic [23:0] beta, logic [15:0] t);
        longint unsigned base;
        longint unsigned acc;
        int k;
        base = {40'b0, beta} << 8;
        acc = base;
        k = 15;
        while (k > 0 && !t[k])
            k--;
        for (k = k - 1; k >= 0; k--)
        begin
            acc = round_mul_q32(acc, acc);
            if (t[k])
                acc = round_mul_q32(acc, base);
        end
        return 64'h1_0000_0000 - acc;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic adam_result_t predict_adam_step(logic signed [31:0] w_i,
            logic signed [31:0] g_i, logic signed [31:0] m_i, logic [30:0] s_i);
        adam_result_t r;
        longint w, g, m, b1, b2, mn, wn;
        longint unsigned s, g2, ssum, sn, mag, mhat, shat, root, denom, q;
        longint unsigned hi, lo, p1, q1, r1, q2;
        logic [15:0] t;
        w = longint'(w_i);
        g = longint'(g_i);
        m = longint'(m_i);
        s = {33'b0, s_i};
        b1 = {40'b0, decay_one};
        b2 = {40'b0, decay_two};
        t = (iteration == 16'd0) ? 16'd1 : iteration;

        mn = clamp_s32((b1 * m + (64'sd16777216 - b1) * g + 64'sd8388608) >>> 24);
        g2 = (longint'(g * g) + 64'd8388608) >> 24;
        ssum = (longint'(b2) * s + longint'(64'sd16777216 - b2) * g2 + 64'd8388608) >> 24;
        sn = (ssum > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : ssum;

        mag = (mn < 0) ? longint'(-mn) : longint'(mn);
        mhat = (mag << 32) / decay_complement(decay_one, t);
        if (mhat > 64'hFF_FFFF_FFFF)
            mhat = 64'hFF_FFFF_FFFF;
        shat = (sn << 32) / decay_complement(decay_two, t);
        if (shat > 64'hFF_FFFF_FFFF)
            shat = 64'hFF_FFFF_FFFF;

        root = int_sqrt(shat << 24);
        denom = (root << 8) + {32'b0, epsilon_q32};

        if (denom == 0)
            q = (mhat != 0) ? 64'h1_0000_0000 : 64'd0;
        else
        begin
            // Split the dividend so that no product overflows 64 bits.
            hi = mhat >> 20;
            lo = mhat & 64'hF_FFFF;
            p1 = {32'b0, step_size} * hi;
            q1 = p1 / denom;
            r1 = p1 % denom;
            if (q1 >= 4096)
                q = 64'h1_0000_0000;
            else
            begin
                q2 = ((r1 << 20) + {32'b0, step_size} * lo) / denom;
                q = (q1 << 20) + q2;
                if (q > 64'h1_0000_0000)
                    q = 64'h1_0000_0000;
            end
        end

        wn = (mn < 0) ? w + longint'(q) : w - longint'(q);
        r.w = 32'(clamp_s32(wn));
        r.m = 32'(mn);
        r.s = sn[30:0];
        return r;
    endfunction

    // Check each strobed result against the oldest pending expectation.
    always @(posedge clk)
    begin
        adam_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_updates.size() == 0)
            begin
                $error("unexpected result: weight_out=%0d", weight_out);
                mismatches++;
            end
            else
            begin
                exp_r = pending_updates.pop_front();
                updates_checked++;
                if (weight_out !== exp_r.w)
                begin
                    $error("weight_out: expected %0d, got %0d", exp_r.w, weight_out);
                    mismatches++;
                end
                if (first_moment_out !== exp_r.m)
                begin
                    $error("first_moment_out: expected %0d, got %0d",
                           exp_r.m, first_moment_out);
                    mismatches++;
                end
                if (second_moment_out !== exp_r.s)
                begin
                    $error("second_moment_out: expected %0d, got %0d",
                           exp_r.s, second_moment_out);
                    mismatches++;
                end
            end
        end
    end

    // Present one element and hold it until the block takes it; then idle
    // for a random gap. With no gap start stays high for the next element.
    task automatic send_element(logic signed [31:0] w, logic signed [31:0] g,
            logic signed [31:0] m, logic [30:0] s, bit has_typed, adam_result_t typed);
        int gap;
        weight_in <= w;
        gradient <= g;
        first_moment_in <= m;
        second_moment_in <= s;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        pending_updates.push_back(has_typed ? typed : predict_adam_step(w, g, m, s));
        elements_sent++;
        case ($urandom_range(0, 19))
            0, 1, 2, 3:     gap = $urandom_range(1, 3);
            4:              gap = $urandom_range(10, 120);
            default:        gap = 0;
        endcase
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drain the pipeline so that a register write sees an idle block.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_updates.size() != 0)
            @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    // One write transfer; valid goes low again before the task returns.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_BETA_ONE:       decay_one = data[23:0];
            CFG_BETA_TWO:       decay_two = data[23:0];
            CFG_LEARNING_RATE:  step_size = data;
            CFG_STABILITY_TERM: epsilon_q32 = data;
            CFG_STEP_COUNT:     iteration = data[15:0];
            default:            ;
        endcase
    endtask

    // Load a whole setting; junk in the unused upper bits checks the masking.
    task automatic load_setting(logic [23:0] b1, logic [23:0] b2, logic [31:0] lr,
            logic [31:0] eps, logic [15:0] t);
        wait_drained();
        write_register(CFG_BETA_ONE, {8'($urandom_range(0, 255)), b1});
        write_register(CFG_BETA_TWO, {8'($urandom_range(0, 255)), b2});
        write_register(CFG_LEARNING_RATE, lr);
        write_register(CFG_STABILITY_TERM, eps);
        write_register(CFG_STEP_COUNT, {16'($urandom_range(0, 65535)), t});
    endtask

    function automatic logic signed [31:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sd0;
            3:       return 32'sd1;
            default: return -32'sd1;
        endcase
    endfunction

    // Random element; the mix leans on realistic magnitudes but still hits
    // extremes, zero gradients (zero denominator when epsilon is zero) and noise.
    task automatic send_random_element();
        logic signed [31:0] w, g, m;
        logic [30:0] s;
        adam_result_t none;
        none = '{default: '0};
        w = $urandom;
        g = $urandom;
        m = $urandom;
        s = 31'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2: ;
            3, 4, 5:
            begin
                // Gradients and moments of order one, as in training.
                g = $signed(g) >>> $urandom_range(4, 12);
                m = $signed(m) >>> $urandom_range(4, 12);
                s = s >> $urandom_range(4, 16);
                w = $signed(w) >>> $urandom_range(0, 6);
            end
            6:
            begin
                g = 32'sd0;
                s = 31'd0;
                if ($urandom_range(0, 1))
                    m = 32'sd0;
            end
            7:
            begin
                w = pick_extreme();
                g = pick_extreme();
                m = pick_extreme();
                s = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0;
            end
            default:
            begin
                g = $signed(g) >>> 20;
                m = $signed(m) >>> 20;
                s = s >> 24;
            end
        endcase
        send_element(w, g, m, s, 1'b0, none);
    endtask

    task automatic run_random(int count);
        repeat (count) send_random_element();
    endtask

    initial
    begin
        directed_row_t rows[$];
        adam_result_t none;
        none = '{default: '0};
        mismatches = 0;
        updates_checked = 0;
        elements_sent = 0;
        start = 1'b0;
        weight_in = '0;
        gradient = '0;
        first_moment_in = '0;
        second_moment_in = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_BETA_ONE;
        cfg_data = '0;
        decay_one = RST_BETA_ONE;
        decay_two = RST_BETA_TWO;
        step_size = RST_LEARNING_RATE;
        epsilon_q32 = RST_STABILITY_TERM;
        iteration = RST_STEP_COUNT;

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table under the reset registers. Zero gradient and moments
        // leave the weight untouched, so those rows carry typed results.
        rows.push_back('{32'sd0, 32'sd0, 32'sd0, 31'd0, 1'b1, '{32'sd0, 32'sd0, 31'd0}});
        rows.push_back('{32'sh7FFF_FFFF, 32'sd0, 32'sd0, 31'd0, 1'b1,
                         '{32'sh7FFF_FFFF, 32'sd0, 31'd0}});
        rows.push_back('{32'sh8000_0000, 32'sd0, 32'sd0, 31'd0, 1'b1,
                         '{32'sh8000_0000, 32'sd0, 31'd0}});
        rows.push_back('{32'sd0, 32'sh7FFF_FFFF, 32'sd0, 31'd0, 1'b0, none});
        rows.push_back('{32'sd0, 32'sh8000_0000, 32'sd0, 31'd0, 1'b0, none});
        rows.push_back('{32'sd0, 32'sd0, 32'sh7FFF_FFFF, 31'd0, 1'b0, none});
        rows.push_back('{32'sd0, 32'sd0, 32'sh8000_0000, 31'd0, 1'b0, none});
        rows.push_back('{32'sd0, 32'sd0, 32'sd0, 31'h7FFF_FFFF, 1'b0, none});
        rows.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF,
                         1'b0, none});
        rows.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF,
                         1'b0, none});
        rows.push_back('{32'sh7FFF_FFF0, -32'sd16777216, -32'sd16777216, 31'd0, 1'b0, none});
        rows.push_back('{32'sh8000_0010, 32'sd16777216, 32'sd16777216, 31'd0, 1'b0, none});
        rows.push_back('{32'sd16777216, 32'sd1677722, 32'sd0, 31'd16777, 1'b0, none});
        rows.push_back('{32'sd0, 32'sd1, -32'sd1, 31'd1, 1'b0, none});
        rows.push_back('{32'sd0, 32'sd0, 32'sd8388608, 31'd0, 1'b0, none});
        foreach (rows[i])
            send_element(rows[i].w, rows[i].g, rows[i].m, rows[i].s,
                         rows[i].has_typed, rows[i].typed);

        run_random(ITEMS_PER_SETTING / 2);
        // Hold off the sender until the pipeline is empty, then resume.
        wait_drained();
        run_random(ITEMS_PER_SETTING / 2);

        // Betas at zero, epsilon zero (zero denominator), step count zero.
        load_setting(24'd0, 24'd0, 32'hFFFF_FFFF, 32'd0, 16'd0);
        send_element(32'sd0, 32'sd0, 32'sd16777216, 31'd0, 1'b0, none);
        send_element(32'sd0, 32'sd0, 32'sd0, 31'd0, 1'b0, none);
        run_random(ITEMS_PER_SETTING);

        // Betas at their top, longest step count, epsilon at its top.
        load_setting(24'hFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        run_random(ITEMS_PER_SETTING / 2);

        // Betas near one with step one: tiny correction, large moments saturate.
        load_setting(24'hFF_FFFF, 24'hFF_FFFF, 32'd1, 32'd0, 16'd1);
        run_random(ITEMS_PER_SETTING / 2);

        // A typical mid-training setting, plus a write to an unused index.
        load_setting(24'hE6_6666, 24'hFF_BE76, $urandom, $urandom_range(0, 4096),
                     16'($urandom_range(2, 200)));
        write_register(CFG_STEP_COUNT + 3'd1, $urandom);
        run_random(ITEMS_PER_SETTING);

        load_setting(24'($urandom), 24'($urandom), $urandom, $urandom, 16'($urandom));
        run_random(ITEMS_PER_SETTING / 2);

        start <= 1'b0;
        @(posedge clk);
        while (pending_updates.size() != 0)
            @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);

        $display("Covered %0d elements (%0d results checked) over six register settings,",
                 elements_sent, updates_checked);
        $display("including zero and full-scale betas, zero epsilon and step count zero.");
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Drop the run if it hangs.
    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
